// ===== design/mss_pkg.sv =====
package mss_pkg;

  localparam int MaxVertices = 64;
  localparam int MaxEdges    = 1024;

  localparam int VtxW   = 7;
  localparam int WgtW   = 32;
  localparam int IdxW   = $clog2(MaxVertices);
  localparam int EdgeAw = $clog2(MaxEdges);
  localparam int TotW   = $clog2(MaxEdges + 1);
  localparam int KeyW   = 2 * IdxW;
  localparam int KeyN   = MaxVertices * MaxVertices;
  localparam int CountW = $clog2(MaxEdges + 1);

  localparam logic ReqLoad  = 1'b0;
  localparam logic ReqSolve = 1'b1;

  typedef struct packed {
    logic                   req_type;
    logic [VtxW-1:0]        from_vertex;
    logic [VtxW-1:0]        to_vertex;
    logic signed [WgtW-1:0] edge_weight;
  } in_item_t;

  typedef struct packed {
    logic            found;
    logic [WgtW-1:0] spread;
  } out_item_t;

  typedef struct packed {
    logic [VtxW-1:0]        from_vertex;
    logic [VtxW-1:0]        to_vertex;
    logic signed [WgtW-1:0] weight;
  } edge_t;

endpackage

// ===== design/mss_ram.sv =====
module mss_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== design/min_spread_spanning_edges.sv =====
// channel | direction | handshake           | payload
// in      | input     | in_valid_i/in_stall_o | in_data_i  (mss_pkg::in_item_t)
// out     | output    | out_valid_o/out_stall_i | out_data_o (mss_pkg::out_item_t)
// cfg     | input     | cfg_we_i             | cfg_data_i (vertex_count)
//
// loads are taken back to back from idle
// a solve runs an insertion sort in the edge ram, then a clearing pass over all
// 4096 entries of the pair count ram, then the window search with its
// connectivity checks and edge updates
// reset clears control state, edge total and vertex_count (to 1); rams hold no reset
// the input stays stalled while a solve is in progress; one result waits in the
// output register while the next edges are loaded
module min_spread_spanning_edges (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  mss_pkg::in_item_t       in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output mss_pkg::out_item_t      out_data_o,
  input  logic                    cfg_we_i,
  input  logic [mss_pkg::VtxW-1:0] cfg_data_i
);

  // one-hot sequencer
  typedef enum logic [15:0] {
    ST_IDLE     = 16'h0001,
    ST_SORT_RI  = 16'h0002,
    ST_SORT_LDT = 16'h0004,
    ST_SORT_RJ  = 16'h0008,
    ST_SORT_CMP = 16'h0010,
    ST_CLR      = 16'h0020,
    ST_LTOP     = 16'h0040,
    ST_CHK_PICK = 16'h0080,
    ST_CHK_OR   = 16'h0100,
    ST_WIN_ADD  = 16'h0200,
    ST_WIN_REM  = 16'h0400,
    ST_ADJ_RD   = 16'h0800,
    ST_ADJ_CNT  = 16'h1000,
    ST_ADJ_RA   = 16'h2000,
    ST_ADJ_RB   = 16'h4000,
    ST_DONE     = 16'h8000
  } state_e;

  localparam int Nv = mss_pkg::MaxVertices;
  localparam int Iw = mss_pkg::IdxW;

  state_e state_q, state_d;

  logic [mss_pkg::VtxW-1:0]  vcount_q;
  logic [mss_pkg::TotW-1:0]  total_q, total_d;
  logic [mss_pkg::TotW-1:0]  i_q, i_d, j_q, j_d, l_q, l_d, r_q, r_d;
  logic [mss_pkg::KeyW-1:0]  clr_q, clr_d;
  mss_pkg::edge_t            t_q, t_d;
  mss_pkg::edge_t            e_q, e_d;
  logic [mss_pkg::WgtW-1:0]  wlast_q, wlast_d;
  logic                      found_q, found_d;
  logic [mss_pkg::WgtW-1:0]  best_q, best_d;
  logic [Nv-1:0]             vis_q, vis_d, proc_q, proc_d;
  logic                      add_q, add_d;
  logic                      out_valid_q;
  mss_pkg::out_item_t        out_q;

  // edge ram ports
  logic                      e_we;
  logic [mss_pkg::EdgeAw-1:0] e_waddr, e_raddr;
  mss_pkg::edge_t            e_wdata, e_rdata;

  // pair count ram ports
  logic                      c_we;
  logic [mss_pkg::KeyW-1:0]  c_waddr, c_raddr;
  logic [mss_pkg::CountW-1:0] c_wdata, c_rdata;

  // adjacency row ram ports
  logic                      w_we;
  logic [Iw-1:0]             w_waddr, w_raddr;
  logic [Nv-1:0]             w_wdata, w_rdata;

  logic                      in_acc;
  logic [mss_pkg::VtxW-1:0]  n_live;
  logic [Nv-1:0]             live_mask;
  logic [Nv-1:0]             pending, low_bit;
  logic [Iw-1:0]             pick;
  logic [mss_pkg::WgtW-1:0]  diff;

  // endpoints of the edge under update
  logic                      e_ok;
  logic [Iw-1:0]             a_idx, b_idx, lo_idx, hi_idx;
  logic [mss_pkg::CountW-1:0] cnt_new;
  logic                      cnt_flip;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // out-of-range vertex counts clamp into 1..max
  always_comb begin
    if (vcount_q == '0) begin
      n_live = mss_pkg::VtxW'(1);
    end else if (int'(vcount_q) > Nv) begin
      n_live = mss_pkg::VtxW'(Nv);
    end else begin
      n_live = vcount_q;
    end
    for (int k = 0; k < Nv; k++) begin
      live_mask[k] = (k < int'(n_live));
    end
  end

  // lowest vertex reached but not yet expanded
  always_comb begin
    pending = vis_q & ~proc_q;
    low_bit = pending & (~pending + Nv'(1));
    pick    = '0;
    for (int k = 0; k < Nv; k++) begin
      if (low_bit[k]) begin
        pick = pick | Iw'(k);
      end
    end
  end

  // edge is counted only with both ends live and distinct
  always_comb begin
    e_ok = (e_q.from_vertex != '0) && (e_q.from_vertex <= n_live) &&
           (e_q.to_vertex != '0) && (e_q.to_vertex <= n_live) &&
           (e_q.from_vertex != e_q.to_vertex);
    a_idx  = Iw'(e_q.from_vertex - mss_pkg::VtxW'(1));
    b_idx  = Iw'(e_q.to_vertex - mss_pkg::VtxW'(1));
    lo_idx = (a_idx < b_idx) ? a_idx : b_idx;
    hi_idx = (a_idx < b_idx) ? b_idx : a_idx;
    cnt_new  = add_q ? (c_rdata + mss_pkg::CountW'(1)) : (c_rdata - mss_pkg::CountW'(1));
    cnt_flip = add_q ? (c_rdata == '0) : (c_rdata == mss_pkg::CountW'(1));
  end

  assign diff = $unsigned(wlast_q) - $unsigned(e_rdata.weight);

  always_comb begin
    state_d = state_q;
    total_d = total_q;
    i_d = i_q; j_d = j_q; l_d = l_q; r_d = r_q;
    clr_d = clr_q;
    t_d = t_q; e_d = e_q;
    wlast_d = wlast_q;
    found_d = found_q; best_d = best_q;
    vis_d = vis_q; proc_d = proc_q;
    add_d = add_q;
    e_we = 1'b0; e_waddr = '0; e_wdata = t_q; e_raddr = '0;
    c_we = 1'b0; c_waddr = {lo_idx, hi_idx}; c_wdata = cnt_new; c_raddr = {lo_idx, hi_idx};
    w_we = 1'b0; w_waddr = a_idx; w_wdata = '0; w_raddr = a_idx;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.req_type == mss_pkg::ReqLoad) begin
            // a full store drops the edge
            if (int'(total_q) < mss_pkg::MaxEdges) begin
              e_we    = 1'b1;
              e_waddr = mss_pkg::EdgeAw'(total_q);
              e_wdata = '{from_vertex: in_data_i.from_vertex,
                          to_vertex:   in_data_i.to_vertex,
                          weight:      in_data_i.edge_weight};
              total_d = total_q + mss_pkg::TotW'(1);
            end
          end else begin
            found_d = 1'b0;
            best_d  = '0;
            if (n_live == mss_pkg::VtxW'(1)) begin
              // single vertex is connected by the empty window
              found_d = 1'b1;
              state_d = ST_DONE;
            end else begin
              i_d     = mss_pkg::TotW'(1);
              state_d = ST_SORT_RI;
            end
          end
        end
      end
      ST_SORT_RI: begin
        e_raddr = mss_pkg::EdgeAw'(i_q);
        if (i_q >= total_q) begin
          clr_d   = '0;
          state_d = ST_CLR;
        end else begin
          state_d = ST_SORT_LDT;
        end
      end
      ST_SORT_LDT: begin
        t_d     = e_rdata;
        j_d     = i_q;
        state_d = ST_SORT_RJ;
      end
      ST_SORT_RJ: begin
        e_raddr = mss_pkg::EdgeAw'(j_q - mss_pkg::TotW'(1));
        if (j_q == '0) begin
          e_we    = 1'b1;
          e_waddr = '0;
          e_wdata = t_q;
          i_d     = i_q + mss_pkg::TotW'(1);
          state_d = ST_SORT_RI;
        end else begin
          state_d = ST_SORT_CMP;
        end
      end
      ST_SORT_CMP: begin
        e_we    = 1'b1;
        e_waddr = mss_pkg::EdgeAw'(j_q);
        if ($signed(e_rdata.weight) > $signed(t_q.weight)) begin
          e_wdata = e_rdata;
          j_d     = j_q - mss_pkg::TotW'(1);
          state_d = ST_SORT_RJ;
        end else begin
          e_wdata = t_q;
          i_d     = i_q + mss_pkg::TotW'(1);
          state_d = ST_SORT_RI;
        end
      end
      ST_CLR: begin
        // counts and adjacency rows cleared together
        c_we    = 1'b1;
        c_waddr = clr_q;
        c_wdata = '0;
        w_we    = 1'b1;
        w_waddr = clr_q[Iw-1:0];
        w_wdata = '0;
        clr_d   = clr_q + mss_pkg::KeyW'(1);
        if (&clr_q) begin
          l_d     = '0;
          r_d     = '0;
          state_d = ST_LTOP;
        end
      end
      ST_LTOP: begin
        if (l_q >= total_q) begin
          state_d = ST_DONE;
        end else begin
          vis_d   = Nv'(1);
          proc_d  = '0;
          state_d = ST_CHK_PICK;
        end
      end
      ST_CHK_PICK: begin
        w_raddr = pick;
        if (pending == '0) begin
          if (vis_q == live_mask) begin
            e_raddr = mss_pkg::EdgeAw'(l_q);
            state_d = ST_WIN_REM;
          end else if (r_q < total_q) begin
            e_raddr = mss_pkg::EdgeAw'(r_q);
            state_d = ST_WIN_ADD;
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          proc_d  = proc_q | low_bit;
          state_d = ST_CHK_OR;
        end
      end
      ST_CHK_OR: begin
        vis_d   = vis_q | (w_rdata & live_mask);
        state_d = ST_CHK_PICK;
      end
      ST_WIN_ADD: begin
        e_d     = e_rdata;
        wlast_d = e_rdata.weight;
        add_d   = 1'b1;
        state_d = ST_ADJ_RD;
      end
      ST_WIN_REM: begin
        e_d   = e_rdata;
        add_d = 1'b0;
        if (!found_q || (diff < best_q)) begin
          found_d = 1'b1;
          best_d  = diff;
        end
        state_d = ST_ADJ_RD;
      end
      ST_ADJ_RD: begin
        if (e_ok) begin
          state_d = ST_ADJ_CNT;
        end else if (add_q) begin
          r_d     = r_q + mss_pkg::TotW'(1);
          vis_d   = Nv'(1);
          proc_d  = '0;
          state_d = ST_CHK_PICK;
        end else begin
          l_d     = l_q + mss_pkg::TotW'(1);
          state_d = ST_LTOP;
        end
      end
      ST_ADJ_CNT: begin
        c_we    = 1'b1;
        w_raddr = a_idx;
        if (cnt_flip) begin
          state_d = ST_ADJ_RA;
        end else if (add_q) begin
          r_d     = r_q + mss_pkg::TotW'(1);
          vis_d   = Nv'(1);
          proc_d  = '0;
          state_d = ST_CHK_PICK;
        end else begin
          l_d     = l_q + mss_pkg::TotW'(1);
          state_d = ST_LTOP;
        end
      end
      ST_ADJ_RA: begin
        w_we    = 1'b1;
        w_waddr = a_idx;
        w_wdata = w_rdata ^ (Nv'(1) << b_idx);
        w_raddr = b_idx;
        state_d = ST_ADJ_RB;
      end
      ST_ADJ_RB: begin
        w_we    = 1'b1;
        w_waddr = b_idx;
        w_wdata = w_rdata ^ (Nv'(1) << a_idx);
        if (add_q) begin
          r_d     = r_q + mss_pkg::TotW'(1);
          vis_d   = Nv'(1);
          proc_d  = '0;
          state_d = ST_CHK_PICK;
        end else begin
          l_d     = l_q + mss_pkg::TotW'(1);
          state_d = ST_LTOP;
        end
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vcount_q    <= mss_pkg::VtxW'(1);
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      if (cfg_we_i) begin
        vcount_q <= cfg_data_i;
      end
      if (state_q == ST_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; j_q <= j_d; l_q <= l_d; r_q <= r_d;
    clr_q   <= clr_d;
    t_q     <= t_d;
    e_q     <= e_d;
    wlast_q <= wlast_d;
    found_q <= found_d;
    best_q  <= best_d;
    vis_q   <= vis_d;
    proc_q  <= proc_d;
    add_q   <= add_d;
    if (state_q == ST_DONE && (!out_valid_q || !out_stall_i)) begin
      out_q.found  <= found_q;
      out_q.spread <= found_q ? best_q : '0;
    end
  end

  // sorted edge list
  mss_ram #(
    .Width($bits(mss_pkg::edge_t)),
    .Depth(mss_pkg::MaxEdges)
  ) u_edge_ram (
    .clk_i  (clk_i),
    .we_i   (e_we),
    .waddr_i(e_waddr),
    .wdata_i(e_wdata),
    .raddr_i(e_raddr),
    .rdata_o(e_rdata)
  );

  // parallel edge count per vertex pair, keyed by the lower index first
  mss_ram #(
    .Width(mss_pkg::CountW),
    .Depth(mss_pkg::KeyN)
  ) u_cnt_ram (
    .clk_i  (clk_i),
    .we_i   (c_we),
    .waddr_i(c_waddr),
    .wdata_i(c_wdata),
    .raddr_i(c_raddr),
    .rdata_o(c_rdata)
  );

  // one adjacency bit row per vertex, a bit set while its pair count is nonzero
  mss_ram #(
    .Width(Nv),
    .Depth(Nv)
  ) u_row_ram (
    .clk_i  (clk_i),
    .we_i   (w_we),
    .waddr_i(w_waddr),
    .wdata_i(w_wdata),
    .raddr_i(w_raddr),
    .rdata_o(w_rdata)
  );

endmodule

// ===== design/mss_checker.sv =====
module mss_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input mss_pkg::out_item_t out_data_o
);

  // stalled result is held
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // no spread reported without a connecting window
  a_spread_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |-> out_data_o.spread == '0)
    else $error("spread nonzero without found");

  // a new result comes only out of a busy solve
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a solve in progress");

endmodule

bind min_spread_spanning_edges mss_checker u_mss_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

// ===== tb/sv/mss_checker.sv =====
module mss_scoreboard (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  mss_pkg::in_item_t        in_data_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  mss_pkg::out_item_t       out_data_i,
  input  logic                     cfg_we_i,
  input  logic [mss_pkg::VtxW-1:0] cfg_data_i,
  output int                       fail_count_o,
  output int                       pending_o,
  output int                       checked_o,
  output int                       found_count_o
);

  // model state
  mss_pkg::edge_t            held_edges [mss_pkg::MaxEdges];
  int unsigned               held_total;
  logic [mss_pkg::VtxW-1:0]  vertex_reg;
  mss_pkg::out_item_t        spans_expected [$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, exp);
    fail_count_o++;
  endtask

  // least spread of a connecting window over the weight-sorted edges
  function automatic mss_pkg::out_item_t predict_span();
    mss_pkg::out_item_t       res;
    mss_pkg::edge_t           sorted_edges [mss_pkg::MaxEdges];
    mss_pkg::edge_t           tmp;
    int                       parent [mss_pkg::MaxVertices];
    int                       n, m, j, r, comps, a, b, ra, rb;
    logic [mss_pkg::WgtW-1:0] d;
    res = '0;
    n = int'(vertex_reg);
    if (n == 0) n = 1;
    if (n > mss_pkg::MaxVertices) n = mss_pkg::MaxVertices;
    if (n == 1) begin
      res.found = 1'b1;
      return res;
    end
    m = int'(held_total);
    for (int i = 0; i < m; i++) begin
      tmp = held_edges[i];
      j = i;
      while (j > 0 && sorted_edges[j-1].weight > tmp.weight) begin
        sorted_edges[j] = sorted_edges[j-1];
        j--;
      end
      sorted_edges[j] = tmp;
    end
    for (int l = 0; l < m; l++) begin
      for (int v = 0; v < mss_pkg::MaxVertices; v++) parent[v] = v;
      comps = n;
      r = l;
      while (r < m && comps > 1) begin
        a = int'(sorted_edges[r].from_vertex);
        b = int'(sorted_edges[r].to_vertex);
        if (a >= 1 && a <= n && b >= 1 && b <= n && a != b) begin
          ra = a - 1;
          while (parent[ra] != ra) ra = parent[ra];
          rb = b - 1;
          while (parent[rb] != rb) rb = parent[rb];
          if (ra != rb) begin
            parent[ra] = rb;
            comps--;
          end
        end
        r++;
      end
      // later left ends only have fewer edges
      if (comps > 1) break;
      d = sorted_edges[r-1].weight - sorted_edges[l].weight;
      if (!res.found || d < res.spread) begin
        res.found  = 1'b1;
        res.spread = d;
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : sample
    mss_pkg::out_item_t exp;
    if (!rst_ni) begin
      held_total    = 0;
      vertex_reg    = mss_pkg::VtxW'(1);
      fail_count_o  = 0;
      checked_o     = 0;
      found_count_o = 0;
      spans_expected.delete();
    end else begin
      if (cfg_we_i) vertex_reg = cfg_data_i;
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.req_type == mss_pkg::ReqLoad) begin
          if (held_total < mss_pkg::MaxEdges) begin
            held_edges[held_total] = '{in_data_i.from_vertex, in_data_i.to_vertex,
                                       in_data_i.edge_weight};
            held_total++;
          end
        end else begin
          spans_expected.push_back(predict_span());
        end
      end
      if (out_valid_i && !out_stall_i) begin
        checked_o++;
        if (out_data_i.found) found_count_o++;
        if (spans_expected.size() == 0) begin
          report("unexpected result", {31'd0, out_data_i.found}, 32'd0);
        end else begin
          exp = spans_expected.pop_front();
          if (out_data_i.found !== exp.found)
            report("found", {31'd0, out_data_i.found}, {31'd0, exp.found});
          if (out_data_i.spread !== exp.spread) report("spread", out_data_i.spread, exp.spread);
        end
      end
    end
    pending_o = spans_expected.size();
  end

  final begin
    if (spans_expected.size() != 0)
      $display("%0d results never arrived", spans_expected.size());
  end

endmodule

// ===== tb/sv/min_spread_spanning_edges_tb.sv =====
module min_spread_spanning_edges_tb;

  localparam int IdleLimit  = 6_000_000;  // a full-store solve at 64 vertices is long
  localparam int HoldCycles = 20_000;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  mss_pkg::in_item_t        in_data_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  mss_pkg::out_item_t       out_data_o;
  logic                     cfg_we_i;
  logic [mss_pkg::VtxW-1:0] cfg_data_i;

  int fail_count, pending, checked, found_count;
  int loads_sent, solves_sent;
  int idle_cycles = 0;
  bit quiet;      // no idling in the closing part
  bit hold_req;   // asks the receiver for a long hold-off
  bit hold_done;  // the long hold-off has been served
  int live_n;     // vertex range used for well-formed edges

  min_spread_spanning_edges dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_data_i
  );

  mss_scoreboard checker_i (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending),
    .checked_o(checked), .found_count_o(found_count)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // watchdog: cycles without any transaction on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no transaction for %0d cycles", IdleLimit);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: random stall bursts, free stretches, one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    hold_done   = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        out_stall_i = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        hold_done   = 1'b1;
        out_stall_i = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk_i);
      end else begin
        out_stall_i = 1'b0;
        repeat ($urandom_range(1, 30) - 1) @(negedge clk_i);
      end
    end
  end

  // offer one transaction, with an optional gap in front; returns at a falling edge
  task automatic send(input mss_pkg::in_item_t it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = it;
    do @(posedge clk_i); while (in_stall_o);
    if (it.req_type == mss_pkg::ReqSolve) solves_sent++;
    else loads_sent++;
    @(negedge clk_i);
  endtask

  task automatic load_edge(input int a, input int b, input logic [31:0] w);
    mss_pkg::in_item_t it;
    it.req_type    = mss_pkg::ReqLoad;
    it.from_vertex = mss_pkg::VtxW'(a);
    it.to_vertex   = mss_pkg::VtxW'(b);
    it.edge_weight = w;
    send(it);
  endtask

  // solve fields other than req_type are don't-care, so fill them with noise
  task automatic solve_now();
    mss_pkg::in_item_t it;
    it             = mss_pkg::in_item_t'($bits(mss_pkg::in_item_t)'({$urandom, $urandom}));
    it.req_type    = mss_pkg::ReqSolve;
    send(it);
  endtask

  // the register changes only with the block idle
  task automatic set_vertex_count(input int v);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_data_i = mss_pkg::VtxW'(v);
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    live_n = (v < 2) ? 2 : (v > mss_pkg::MaxVertices ? mss_pkg::MaxVertices : v);
  endtask

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(0, 16)) - 8);
      2: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'h0;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom_range(0, 1000);
    endcase
  endfunction

  task automatic random_edge();
    int a, b;
    case ($urandom_range(0, 9))
      0: begin a = $urandom_range(0, 127); b = $urandom_range(0, 127); end
      1: begin a = $urandom_range(1, live_n); b = a; end
      default: begin a = $urandom_range(1, live_n); b = $urandom_range(1, live_n); end
    endcase
    load_edge(a, b, pick_weight());
  endtask

  int phase_counts [13] = '{64, 2, 3, 5, 8, 1, 4, 6, 0, 7, 12, 3, 2};

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_data_i  = '0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    live_n      = 2;
    loads_sent  = 0;
    solves_sent = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: single vertex with nothing loaded, then zero and oversize counts
    solve_now();
    set_vertex_count(0);
    solve_now();
    set_vertex_count(127);
    load_edge(1, 64, 32'h8000_0000);
    load_edge(64, 1, 32'h7fff_ffff);
    load_edge(0, 5, 32'h0);            // endpoint of zero
    load_edge(127, 127, 32'hffff_ffff); // endpoint above range
    load_edge(3, 3, 32'd7);            // self loop
    load_edge(64, 2, 32'd1);
    solve_now();
    set_vertex_count(2);
    load_edge(1, 2, 32'h8000_0000);
    load_edge(2, 1, 32'h7fff_ffff);
    solve_now();
    solve_now();                        // repeated solve over the same edges
    set_vertex_count(3);
    load_edge(2, 3, 32'd5);
    solve_now();
    set_vertex_count(64);
    solve_now();

    // random phases, mostly well-formed edges in range, a solve now and then
    foreach (phase_counts[p]) begin
      set_vertex_count(phase_counts[p]);
      for (int i = 0; i < 60; i++) begin
        if (p == 3 && i == 10) begin
          // two solves behind a held result fill the block and stall the input
          hold_req = 1'b1;
          solve_now();
          solve_now();
        end
        if ($urandom_range(0, 7) == 0) solve_now();
        else random_edge();
      end
      solve_now();
    end

    // closing part without idling: overfill the store, then one full solve
    quiet = 1'b1;
    set_vertex_count(64);
    for (int i = 0; loads_sent < mss_pkg::MaxEdges + 8; i++)
      load_edge($urandom_range(1, 64), $urandom_range(1, 64), 32'd2_100_000_000 + i);
    solve_now();

    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    $display("sent %0d edge loads and %0d solves over vertex counts 0..127", loads_sent,
             solves_sent);
    $display("checked %0d results, %0d of them connected", checked, found_count);
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== min_spread_spanning_edges.f =====
design/mss_pkg.sv
design/mss_ram.sv
design/min_spread_spanning_edges.sv
design/mss_checker.sv
tb/sv/mss_checker.sv
tb/sv/min_spread_spanning_edges_tb.sv
